// ===== hdl/frlm_pkg.sv =====
// shared types and constants for the frame rate limiter and meter
package frlm_pkg;

    localparam int WORK_W     = 24;
    localparam int INTERVAL_W = 24;
    localparam int DELAY_W    = 10;
    localparam int FPS_W      = 28;
    localparam int MAX_FPS_W  = 10;
    localparam int PERIOD_W   = 20;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FPS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 8'd1;

    localparam logic [PERIOD_W-1:0]   US_PER_SECOND    = 20'd1000000;
    localparam logic [MAX_FPS_W-1:0]  US_PER_MS        = 10'd1000;
    localparam logic [INTERVAL_W-1:0] ZERO_INTERVAL_US = 24'd1000;
    localparam longint unsigned       FPS_SCALE_Q8     = 64'd256000000;

    typedef struct packed {
        logic [WORK_W-1:0]     work_time_us;
        logic [INTERVAL_W-1:0] interval_us;
    } in_word_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_ms;
        logic [FPS_W-1:0]   fps_q8;
    } out_word_t;

endpackage

// ===== hdl/frlm_ram.sv =====
// generic single write port ram with registered read
module frlm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/frlm_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module frlm_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] shift_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    // shift one dividend bit into the partial remainder
    assign trial    = {rem_reg, shift_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= num;
            rem_reg   <= '0;
            den_reg   <= den;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[NUM_W-2:0], ge};
            rem_reg   <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = shift_reg;

endmodule

// ===== hdl/frlm_win.sv =====
// sliding window of interval samples with running sum and fill count
module frlm_win #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [frlm_pkg::INTERVAL_W-1:0]             sample,
    output logic                                        done,
    output logic [frlm_pkg::INTERVAL_W+$clog2(WINDOW_LEN)-1:0] sum,
    output logic [$clog2(WINDOW_LEN+1)-1:0]             count
);

    localparam int SUM_W = frlm_pkg::INTERVAL_W + $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int AW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic [AW-1:0]                   slot_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic                            update_reg;
    logic                            done_reg;
    logic [frlm_pkg::INTERVAL_W-1:0] sample_reg;

    logic [frlm_pkg::INTERVAL_W-1:0] old_sample;
    logic                            full;
    logic [SUM_W-1:0]                sum_next;
    logic [AW-1:0]                   slot_next;

    // the old entry is only used once the window is full, so the
    // never-written contents after reset are never used
    frlm_ram #(
        .WIDTH (frlm_pkg::INTERVAL_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (update_reg),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (slot_reg),
        .rdata (old_sample)
    );

    assign full      = (count_reg == CNT_W'(WINDOW_LEN));
    assign sum_next  = sum_reg - (full ? SUM_W'(old_sample) : '0) + SUM_W'(sample_reg);
    assign slot_next = (slot_reg == AW'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            update_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            update_reg <= start;
            done_reg   <= update_reg;
            if (update_reg)
            begin
                sum_reg  <= sum_next;
                slot_reg <= slot_next;
                if (!full)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sample_reg <= sample;
        end
    end

    assign done  = done_reg;
    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

// ===== hdl/frame_rate_limiter_meter_core.sv =====
// frame rate limiter and meter, top level
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_data   : work_time_us, interval_us
//  out     | out_valid / out_ready| out_data  : delay_ms, fps_q8
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (0 max_fps, 1 limit_enable)
//
//  a word is taken only while idle; its result is loaded into the output register once
//  the rate division and, when a delay is computed, the period and delay divisions in
//  a row have finished; in_ready returns in the cycle after that load
//  reset clears config, window sum, slot and fill count; ring ram is not swept
//  a finished word waits in the output register while the next word is taken, and the
//  next finished word holds the sequencer and input until it frees; cfg_ready always high
module frame_rate_limiter_meter_core #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  frlm_pkg::in_word_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output frlm_pkg::out_word_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [frlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frlm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SUM_W = frlm_pkg::INTERVAL_W + $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    // numerator of the rate division: scale times fill count
    localparam int NUM_W = $clog2(frlm_pkg::FPS_SCALE_Q8 * WINDOW_LEN + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WIN  = 3'd1;
    localparam logic [2:0] S_PER  = 3'd2;
    localparam logic [2:0] S_DLY  = 3'd3;
    localparam logic [2:0] S_FPS  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [frlm_pkg::MAX_FPS_W-1:0]    max_fps_reg;
    logic                              limit_enable_reg;
    logic                              limit_reg;
    logic [frlm_pkg::WORK_W-1:0]       work_reg;
    logic [frlm_pkg::DELAY_W-1:0]      delay_reg;
    logic                              out_valid_reg;
    frlm_pkg::out_word_t               out_data_reg;

    logic                              in_accept;
    logic [frlm_pkg::INTERVAL_W-1:0]   sample;

    logic                              win_done;
    logic [SUM_W-1:0]                  win_sum;
    logic [CNT_W-1:0]                  win_count;

    logic                              fps_start;
    logic                              fps_busy;
    logic [NUM_W-1:0]                  fps_num;
    logic [NUM_W-1:0]                  fps_quo;

    logic                              sd_start;
    logic                              sd_busy;
    logic [frlm_pkg::PERIOD_W-1:0]     sd_num;
    logic [frlm_pkg::MAX_FPS_W-1:0]    sd_den;
    logic [frlm_pkg::PERIOD_W-1:0]     sd_quo;

    logic                              period_over;
    logic                              out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // a zero interval counts as one millisecond
    assign sample = (in_data.interval_us == '0) ? frlm_pkg::ZERO_INTERVAL_US
                                                : in_data.interval_us;

    frlm_win #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_win (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .sample (sample),
        .done   (win_done),
        .sum    (win_sum),
        .count  (win_count)
    );

    // rate: scale * count / sum, the sum is never zero here
    assign fps_start = (state_reg == S_WIN) && win_done;
    assign fps_num   = NUM_W'(frlm_pkg::FPS_SCALE_Q8) * NUM_W'(win_count);

    frlm_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_fps_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fps_start),
        .num   (fps_num),
        .den   (win_sum),
        .busy  (fps_busy),
        .quo   (fps_quo)
    );

    // shared small divider: first the target period, then the delay in ms
    assign period_over = (frlm_pkg::WORK_W'(sd_quo) > work_reg);
    assign sd_start    = (fps_start && limit_reg)
                      || ((state_reg == S_PER) && !sd_busy && period_over);
    assign sd_num      = (state_reg == S_WIN) ? frlm_pkg::US_PER_SECOND
                                              : sd_quo - work_reg[frlm_pkg::PERIOD_W-1:0];
    assign sd_den      = (state_reg == S_WIN) ? max_fps_reg : frlm_pkg::US_PER_MS;

    frlm_div #(
        .NUM_W (frlm_pkg::PERIOD_W),
        .DEN_W (frlm_pkg::MAX_FPS_W)
    ) u_small_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sd_start),
        .num   (sd_num),
        .den   (sd_den),
        .busy  (sd_busy),
        .quo   (sd_quo)
    );

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                if (win_done)
                begin
                    state_next = limit_reg ? S_PER : S_FPS;
                end
            end
            S_PER:
            begin
                if (!sd_busy)
                begin
                    state_next = period_over ? S_DLY : S_FPS;
                end
            end
            S_DLY:
            begin
                if (!sd_busy)
                begin
                    state_next = S_FPS;
                end
            end
            S_FPS:
            begin
                if (!fps_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            max_fps_reg      <= '0;
            limit_enable_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    frlm_pkg::REG_MAX_FPS:
                    begin
                        max_fps_reg <= cfg_data[frlm_pkg::MAX_FPS_W-1:0];
                    end
                    frlm_pkg::REG_LIMIT_ENABLE:
                    begin
                        limit_enable_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // word payload and per-word flags
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            work_reg  <= in_data.work_time_us;
            limit_reg <= limit_enable_reg && (max_fps_reg != '0);
        end
        if (fps_start)
        begin
            delay_reg <= '0;
        end
        else if ((state_reg == S_DLY) && !sd_busy)
        begin
            delay_reg <= sd_quo[frlm_pkg::DELAY_W-1:0];
        end
        if (out_load)
        begin
            out_data_reg.delay_ms <= delay_reg;
            out_data_reg.fps_q8   <= fps_quo[frlm_pkg::FPS_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the frame rate limiter and meter core
`timescale 1ns / 100ps

module testbench;

    // ring length of the rate window, same as the block default
    localparam int WINDOW      = 10;
    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 5;
    // the limit leaves plenty of room over the slowest correct run
    localparam int CYCLE_LIMIT = 600000;
    localparam int BLOCK_ITEMS = 100;
    localparam int BLOCKS      = 7;
    localparam int HOLD_CYCLES = 800;
    localparam int TAIL_CYCLES = 100;

    typedef logic [frlm_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [frlm_pkg::CFG_DATA_W-1:0] cfg_val_t;
    typedef logic [frlm_pkg::WORK_W-1:0]     work_t;
    typedef logic [frlm_pkg::INTERVAL_W-1:0] interval_t;

    // indexes with no register behind them
    localparam cfg_idx_t IDX_UNUSED_LOW  = 8'd2;
    localparam cfg_idx_t IDX_UNUSED_HIGH = 8'hFF;

    // predicts delay and average rate for each frame word and checks the output words
    class frame_rate_scoreboard;
        interval_t                        ring [WINDOW];
        longint unsigned                  window_sum;
        int unsigned                      slot;
        int unsigned                      fill;
        logic [frlm_pkg::MAX_FPS_W-1:0]   max_fps;
        logic                             limit_en;
        frlm_pkg::out_word_t              expected_q [$];
        int unsigned                      mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            window_sum = 0;
            slot       = 0;
            fill       = 0;
            max_fps    = '0;
            limit_en   = 1'b0;
            mismatches = 0;
        endfunction

        // mirror of a register write, unknown indexes fall through
        function void write_reg(cfg_idx_t idx, cfg_val_t data);
            if (idx == frlm_pkg::REG_MAX_FPS)
                max_fps = data[frlm_pkg::MAX_FPS_W-1:0];
            else if (idx == frlm_pkg::REG_LIMIT_ENABLE)
                limit_en = data[0];
        endfunction

        // one accepted frame word gives exactly one expected output word
        function void note_input(frlm_pkg::in_word_t w);
            int unsigned         period;
            int unsigned         delay;
            int unsigned         sample;
            longint unsigned     rate;
            frlm_pkg::out_word_t exp_word;
            delay = 0;
            if (limit_en && max_fps != 0) begin
                period = int'(frlm_pkg::US_PER_SECOND) / int'(max_fps);
                if (period > w.work_time_us)
                    delay = (period - w.work_time_us) / int'(frlm_pkg::US_PER_MS);
            end
            sample = (w.interval_us == 0) ? int'(frlm_pkg::ZERO_INTERVAL_US)
                                          : w.interval_us;
            if (fill >= WINDOW)
                window_sum -= ring[slot];
            else
                fill++;
            ring[slot]  = sample[frlm_pkg::INTERVAL_W-1:0];
            window_sum += sample;
            slot        = (slot + 1 >= WINDOW) ? 0 : slot + 1;
            rate = (frlm_pkg::FPS_SCALE_Q8 * fill) / window_sum;
            exp_word.delay_ms = delay[frlm_pkg::DELAY_W-1:0];
            exp_word.fps_q8   = rate[frlm_pkg::FPS_W-1:0];
            expected_q.push_back(exp_word);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(frlm_pkg::out_word_t got);
            frlm_pkg::out_word_t exp_word;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word delay %0d fps %0d",
                                          got.delay_ms, got.fps_q8));
            end
            else begin
                exp_word = expected_q.pop_front();
                if (got.delay_ms !== exp_word.delay_ms)
                    report_mismatch($sformatf("delay_ms got %0d want %0d",
                                              got.delay_ms, exp_word.delay_ms));
                if (got.fps_q8 !== exp_word.fps_q8)
                    report_mismatch($sformatf("fps_q8 got %0d want %0d",
                                              got.fps_q8, exp_word.fps_q8));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    frlm_pkg::in_word_t    in_data;
    logic                  out_valid;
    logic                  out_ready;
    frlm_pkg::out_word_t   out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    cfg_val_t              cfg_data;

    frame_rate_scoreboard  sb;

    // idle odds in percent, changed between phases
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // long receiver hold-off, raised by its own process
    bit          recv_hold;
    int unsigned cycle_count;

    frame_rate_limiter_meter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run watchdog, counts cycles and gives up at the limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: ready drops at random or for the whole hold-off
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // output monitor, every word taken goes to the scoreboard
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // register write on the cfg channel, done only while the block is idle
    task write_reg(cfg_idx_t idx, cfg_val_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_index <= cfg_idx_t'($urandom_range(255));
        cfg_data  <= cfg_val_t'($urandom_range(65535));
    endtask

    // offer one frame word, valid stays up until the handshake
    task send_frame(frlm_pkg::in_word_t w);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
    endtask

    // random sender gaps, each idle cycle drops valid and scrambles the payload
    task sender_gaps();
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            in_data  <= frlm_pkg::in_word_t'({$urandom, $urandom});
        end
    endtask

    task send_with_gaps(frlm_pkg::in_word_t w);
        sender_gaps();
        send_frame(w);
    endtask

    task frame(work_t work, interval_t interval);
        frlm_pkg::in_word_t w;
        w.work_time_us = work;
        w.interval_us  = interval;
        send_with_gaps(w);
    endtask

    // drop valid and wait until every expected word has come back
    task drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task hold_receiver(int unsigned n);
        recv_hold = 1'b1;
        repeat (n) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    // mostly plausible frame timings, with extremes and full-range noise mixed in
    function frlm_pkg::in_word_t random_frame();
        frlm_pkg::in_word_t w;
        case ($urandom_range(9))
            0:       w.work_time_us = '0;
            1:       w.work_time_us = '1;
            2:       w.work_time_us = work_t'($urandom);
            3:       w.work_time_us = work_t'($urandom_range(0, 1000000));
            default: w.work_time_us = work_t'($urandom_range(0, 40000));
        endcase
        case ($urandom_range(11))
            0:       w.interval_us = '0;
            1:       w.interval_us = '1;
            2:       w.interval_us = interval_t'($urandom);
            3:       w.interval_us = interval_t'($urandom_range(1, 20));
            4:       w.interval_us = interval_t'($urandom_range(0, 2000000));
            default: w.interval_us = interval_t'($urandom_range(900, 70000));
        endcase
        return w;
    endfunction

    task random_block(int unsigned blk);
        for (int i = 0; i < BLOCK_ITEMS; i++)
        begin
            // long hold-off with the sender still pushing, the block backs up
            if (blk == 4 && i == 10)
                fork
                    hold_receiver(HOLD_CYCLES);
                join_none
            // sender waits for everything outstanding once
            if (blk == 5 && i == 50)
                drain_results();
            send_with_gaps(random_frame());
        end
    endtask

    // register setting for each random block, extremes among them
    task config_block(int unsigned blk);
        case (blk)
            0: begin write_reg(frlm_pkg::REG_MAX_FPS, 16'd1000);
                     write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'd1); end
            1: begin write_reg(frlm_pkg::REG_MAX_FPS, 16'd1);
                     write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'd1); end
            2: begin write_reg(frlm_pkg::REG_MAX_FPS, cfg_val_t'($urandom_range(1, 1000))); end
            3: begin write_reg(frlm_pkg::REG_MAX_FPS, 16'd0);
                     write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'd1); end
            4: begin write_reg(frlm_pkg::REG_MAX_FPS, cfg_val_t'($urandom_range(65535)));
                     write_reg(frlm_pkg::REG_LIMIT_ENABLE,
                               cfg_val_t'($urandom_range(65535)) | 16'd1); end
            5: begin write_reg(frlm_pkg::REG_MAX_FPS, cfg_val_t'($urandom_range(20, 240)));
                     write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'd0); end
            default:
               begin write_reg(frlm_pkg::REG_MAX_FPS, cfg_val_t'($urandom_range(1, 1000)));
                     write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'hFFFF); end
        endcase
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 11;
        recv_idle_pct = 73;
        recv_hold     = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_LEN) @(negedge clk);
        rst_n <= 1'b1;

        // reset config: limiting off, zero interval, full-scale fields
        frame('0, '0);
        frame('1, '1);
        frame(24'd12345, 24'd1);
        drain_results();

        // 1000 fps target, period of 1000 us
        write_reg(frlm_pkg::REG_MAX_FPS, 16'd1000);
        write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'd1);
        frame(24'd0, 24'd1000);
        frame(24'd999, 24'd1);
        frame(24'd1000, 24'd16666);
        frame('1, '0);
        drain_results();

        // slowest target, delay up to a full second
        write_reg(frlm_pkg::REG_MAX_FPS, 16'd1);
        frame(24'd0, 24'd1);
        frame(24'd999, 24'd33333);
        frame(24'd999999, 24'd1);
        frame(24'd1000000, '1);
        drain_results();

        // zero rate with enable on, then a rate with enable off
        write_reg(frlm_pkg::REG_MAX_FPS, 16'd0);
        frame(24'd0, 24'd33333);
        drain_results();
        write_reg(frlm_pkg::REG_MAX_FPS, 16'd60);
        write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'd0);
        frame(24'd0, 24'd16667);
        drain_results();

        // writes to unknown indexes change nothing, then enable back on
        write_reg(IDX_UNUSED_LOW, 16'hFFFF);
        write_reg(IDX_UNUSED_HIGH, 16'h0000);
        write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'hFFFF);
        frame(24'd0, 24'd16667);
        frame(24'd16665, 24'd0);
        drain_results();

        // register values masked to their widths
        write_reg(frlm_pkg::REG_MAX_FPS, 16'hFFFF);
        frame(24'd0, 24'd1);
        drain_results();
        write_reg(frlm_pkg::REG_LIMIT_ENABLE, 16'hFFFE);
        frame(24'd0, 24'd1);
        drain_results();

        // random part, idle pattern changes by phase
        for (int unsigned blk = 0; blk < BLOCKS; blk++)
        begin
            if (blk < 2)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 73;
            end
            else if (blk < 4)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            config_block(blk);
            random_block(blk);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
